// ----- hw/rtl/psat_pkg.sv -----
// package for the per-node selective ack tracker
// shared types and constants, no dependencies
`default_nettype none
package psat_pkg;
  localparam int unsigned NumTrackers = 8;
  localparam int unsigned IdxW = $clog2(NumTrackers);
  localparam logic [7:0] RebaseLimit = 8'd128;
  localparam logic [7:0] MaskLen = 8'd16;

  typedef enum logic {
    CMD_RECEIPT = 1'b0,
    CMD_FLUSH   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] node_id;
    logic [7:0] seq;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  out_node;
    logic [7:0]  acked_base;
    logic [15:0] ack_bits;
    logic [7:0]  last_seq;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            scan_step;
    logic            commit;
    logic [IdxW-1:0] idx;
  } psat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic changed;
    logic clean_only;
  } psat_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/psat_ctrl.sv -----
// controller fsm for the tracker: walks the slot table one entry a cycle
// depends on psat_pkg
`default_nettype none
module psat_ctrl import psat_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd_flush,
  output logic            out_valid,
  input  wire logic       out_stall,
  output psat_cmd_t       cmd,
  input  wire psat_stat_t stat,
  input  wire logic [IdxW-1:0] flush_next
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  localparam logic [IdxW:0] Last = (IdxW+1)'(NumTrackers - 1);

  state_t state_r, state_nxt;
  logic [IdxW:0] cnt_r, cnt_nxt;
  logic flush_r, flush_nxt;
  logic [IdxW-1:0] idx;

  always_comb begin
    if (flush_r) idx = IdxW'((IdxW+1)'(flush_next) + cnt_r >= (IdxW+1)'(NumTrackers)
                      ? (IdxW+1)'(flush_next) + cnt_r - (IdxW+1)'(NumTrackers)
                      : (IdxW+1)'(flush_next) + cnt_r);
    else idx = cnt_r[IdxW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    flush_nxt = flush_r;
    cmd = '0;
    cmd.idx = idx;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_SCAN;
          cnt_nxt = '0;
          flush_nxt = cmd_flush;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (flush_r && stat.changed) state_nxt = S_DONE;
        else if (!flush_r && stat.hit) state_nxt = S_DONE;
        else if (cnt_r == Last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      flush_r <= flush_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_outonly: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("out valid outside out state");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("accepting while result pending");
endmodule
`default_nettype wire

// ----- hw/rtl/psat_dp.sv -----
// datapath for the tracker: slot table, scan registers, fold and result
// depends on psat_pkg
`default_nettype none
module psat_dp import psat_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_word,
  input  wire psat_cmd_t cmd,
  output psat_stat_t     stat,
  output logic [IdxW-1:0] flush_next,
  output out_word_t      out_word
);
  logic [NumTrackers-1:0] used_r, used_nxt;
  logic [7:0]  node_r [NumTrackers];
  logic        start_r [NumTrackers];
  logic [7:0]  base_r [NumTrackers];
  logic [15:0] mask_r [NumTrackers];
  logic        dirty_r [NumTrackers];
  logic [7:0]  dseq_r [NumTrackers];
  logic        sv_r [NumTrackers];
  logic [7:0]  sbase_r [NumTrackers];
  logic [15:0] smask_r [NumTrackers];
  logic [IdxW-1:0] fnext_r;

  in_word_t iw_r;
  logic found_r, havefree_r, emit_r;
  logic [IdxW-1:0] slot_r, free_r;
  out_word_t ow_r, ow_nxt;

  logic hit, freeslot, eligible, same;
  always_comb begin
    hit = used_r[cmd.idx] && node_r[cmd.idx] == iw_r.node_id;
    freeslot = !used_r[cmd.idx];
    eligible = used_r[cmd.idx] && start_r[cmd.idx] && dirty_r[cmd.idx];
    same = sv_r[cmd.idx] && sbase_r[cmd.idx] == base_r[cmd.idx]
           && smask_r[cmd.idx] == mask_r[cmd.idx];
    stat.hit = hit;
    stat.changed = eligible && !same;
    stat.clean_only = eligible && same;
  end
  assign flush_next = fnext_r;

  // fold of one sequence into a tracker
  logic [7:0] cb, nb, diff;
  logic [15:0] cm, nm, om;
  logic [4:0] lead;
  logic st, newslot;
  logic [IdxW-1:0] ts;
  always_comb begin
    newslot = !found_r;
    ts = found_r ? slot_r : free_r;
    st = newslot ? 1'b0 : start_r[ts];
    cb = newslot ? 8'd0 : base_r[ts];
    cm = newslot ? 16'd0 : mask_r[ts];
    diff = iw_r.seq - cb;
    nb = cb;
    nm = cm;
    om = '0;
    lead = '0;
    if (!st) begin
      nb = iw_r.seq;
      nm = '0;
    end else if (diff == 8'd0 || diff >= RebaseLimit) begin
      nb = cb;
    end else if (diff > MaskLen) begin
      nb = iw_r.seq;
      nm = '0;
    end else begin
      om = cm | (16'd1 << (diff - 8'd1));
      lead = 5'd16;
      for (int k = 15; k >= 0; k--) if (!om[k]) lead = 5'(k);
      nb = cb + 8'(lead);
      nm = 16'({16'd0, om} >> lead);
    end
  end

  always_comb begin
    ow_nxt = ow_r;
    used_nxt = used_r;
    if (cmd.commit) begin
      ow_nxt = '0;
      if (iw_r.cmd == CMD_RECEIPT) begin
        ow_nxt.out_node = iw_r.node_id;
        if (found_r || havefree_r) begin
          used_nxt[ts] = 1'b1;
          ow_nxt.accepted = 1'b1;
          ow_nxt.acked_base = nb;
          ow_nxt.ack_bits = nm;
          ow_nxt.last_seq = iw_r.seq;
        end
      end else if (emit_r) begin
        ow_nxt.accepted = 1'b1;
        ow_nxt.out_node = node_r[slot_r];
        ow_nxt.acked_base = base_r[slot_r];
        ow_nxt.ack_bits = mask_r[slot_r];
        ow_nxt.last_seq = dseq_r[slot_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fnext_r <= '0;
    end else begin
      used_r <= used_nxt;
      if (cmd.commit && iw_r.cmd == CMD_FLUSH && emit_r)
        fnext_r <= (slot_r == IdxW'(NumTrackers - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
    if (cmd.load) begin
      iw_r <= in_word;
      found_r <= 1'b0;
      havefree_r <= 1'b0;
      emit_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (iw_r.cmd == CMD_RECEIPT) begin
        if (hit) begin
          found_r <= 1'b1;
          slot_r <= cmd.idx;
        end
        if (freeslot && !havefree_r) begin
          havefree_r <= 1'b1;
          free_r <= cmd.idx;
        end
      end else begin
        if (stat.changed) begin
          emit_r <= 1'b1;
          slot_r <= cmd.idx;
        end
        if (stat.clean_only) dirty_r[cmd.idx] <= 1'b0;
      end
    end
    if (cmd.commit) begin
      if (iw_r.cmd == CMD_RECEIPT) begin
        if (found_r || havefree_r) begin
          node_r[ts] <= iw_r.node_id;
          start_r[ts] <= 1'b1;
          base_r[ts] <= nb;
          mask_r[ts] <= nm;
          dirty_r[ts] <= 1'b1;
          dseq_r[ts] <= iw_r.seq;
          if (newslot) begin
            sv_r[ts] <= 1'b0;
            sbase_r[ts] <= '0;
            smask_r[ts] <= '0;
          end
        end
      end else if (emit_r) begin
        sv_r[slot_r] <= 1'b1;
        sbase_r[slot_r] <= base_r[slot_r];
        smask_r[slot_r] <= mask_r[slot_r];
        dirty_r[slot_r] <= 1'b0;
      end
    end
  end

  assign out_word = ow_r;

  a_fnext: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && iw_r.cmd == CMD_FLUSH && !emit_r) |=> $stable(fnext_r))
    else $error("flush pointer moved without emit");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(used_r)) else $error("slot use changed outside commit");
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && iw_r.cmd == CMD_RECEIPT && !found_r && !havefree_r)
    |=> !ow_r.accepted) else $error("full table accepted receipt");
endmodule
`default_nettype wire

// ----- hw/rtl/per_node_selective_ack_tracker.sv -----
// top level of the per-node selective ack tracker
// depends on psat_pkg, psat_ctrl and psat_dp
//
// usage: one input word per item on in_word (cmd, node_id, seq), taken when
// in_valid is high and in_stall low. cmd 0 is a receipt: the node's tracker is
// found or the lowest free one claimed, the sequence is folded in and the
// updated tracker is returned. cmd 1 is a flush: trackers are scanned
// round-robin for a dirty one that changed since last sent, which is returned.
// every item gives exactly one output word on out_word with out_valid.
// order of work: the item is accepted, the slots are scanned one slot per cycle
// (stopping at a hit or at the first changed tracker), the result is committed
// and the word is then offered. one item is in flight at a time; in_stall stays
// high until the result is taken. while out_stall is high the output word is
// held unchanged. reset clears all slot-use bits and the flush pointer; no
// clearing pass.
`default_nettype none
module per_node_selective_ack_tracker import psat_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);
  psat_cmd_t  cmd;
  psat_stat_t stat;
  logic [IdxW-1:0] flush_next;

  psat_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .cmd_flush(in_word.cmd == CMD_FLUSH),
    .out_valid, .out_stall, .cmd, .stat, .flush_next
  );

  psat_dp u_dp (
    .clk, .rst_n, .in_word, .cmd, .stat, .flush_next, .out_word
  );
endmodule
`default_nettype wire

// ----- tb/sv/per_node_selective_ack_tracker_tb.sv -----
// testbench for the per-node selective ack tracker
// drives receipt and flush words, predicts each output word, checks in order
// depends on psat_pkg and per_node_selective_ack_tracker
`default_nettype none
module per_node_selective_ack_tracker_tb;
  import psat_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  int unsigned idle_pct = 15;
  int errors = 0;
  out_word_t ack_q[$];

  // tracker table shadow
  logic       t_used [NumTrackers];
  logic [7:0] t_node [NumTrackers];
  logic       t_started [NumTrackers];
  logic [7:0] t_base [NumTrackers];
  logic [15:0] t_mask [NumTrackers];
  logic       t_dirty [NumTrackers];
  logic [7:0] t_dseq [NumTrackers];
  logic       t_svalid [NumTrackers];
  logic [7:0] t_sbase [NumTrackers];
  logic [15:0] t_smask [NumTrackers];
  int unsigned flush_ptr = 0;

  per_node_selective_ack_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_word_t track_word(in_word_t w);
    out_word_t r;
    int t;
    int fr;
    logic [7:0] d;
    int unsigned i;
    r = '0;
    t = -1;
    fr = -1;
    if (w.cmd == CMD_RECEIPT) begin
      r.out_node = w.node_id;
      for (int k = 0; k < NumTrackers; k++) begin
        if (t < 0 && t_used[k] && t_node[k] == w.node_id) t = k;
        if (!t_used[k] && fr < 0) fr = k;
      end
      if (t < 0 && fr >= 0) begin
        t = fr;
        t_used[t] = 1'b1; t_node[t] = w.node_id; t_started[t] = 1'b0;
        t_base[t] = '0; t_mask[t] = '0; t_dirty[t] = 1'b0; t_dseq[t] = '0;
        t_svalid[t] = 1'b0; t_sbase[t] = '0; t_smask[t] = '0;
      end
      if (t < 0) return r;
      if (!t_started[t]) begin
        t_base[t] = w.seq; t_mask[t] = '0; t_started[t] = 1'b1;
      end else begin
        d = w.seq - t_base[t];
        if (d != 0 && d < RebaseLimit) begin
          if (d > MaskLen) begin
            t_base[t] = w.seq; t_mask[t] = '0;
          end else begin
            t_mask[t][d - 1] = 1'b1;
            while (t_mask[t][0]) begin
              t_base[t] = t_base[t] + 8'd1;
              t_mask[t] = t_mask[t] >> 1;
            end
          end
        end
      end
      t_dirty[t] = 1'b1; t_dseq[t] = w.seq;
      r.accepted = 1'b1; r.acked_base = t_base[t];
      r.ack_bits = t_mask[t]; r.last_seq = w.seq;
      return r;
    end
    for (int unsigned off = 0; off < NumTrackers; off++) begin
      i = (flush_ptr + off) % NumTrackers;
      if (!t_used[i] || !t_started[i] || !t_dirty[i]) continue;
      if (t_svalid[i] && t_sbase[i] == t_base[i] && t_smask[i] == t_mask[i]) begin
        t_dirty[i] = 1'b0;
        continue;
      end
      r.accepted = 1'b1; r.out_node = t_node[i]; r.acked_base = t_base[i];
      r.ack_bits = t_mask[i]; r.last_seq = t_dseq[i];
      t_svalid[i] = 1'b1; t_sbase[i] = t_base[i]; t_smask[i] = t_mask[i];
      t_dirty[i] = 1'b0;
      flush_ptr = (i + 1) % NumTrackers;
      return r;
    end
    return r;
  endfunction

  task automatic send_word(cmd_e c, logic [7:0] node, logic [7:0] sq);
    in_word_t w;
    w.cmd = c; w.node_id = node; w.seq = sq;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    ack_q.push_back(track_word(w));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (ack_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ack_q.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        out_word_t e;
        e = ack_q.pop_front();
        if (e.accepted !== out_word.accepted) begin
          $error("accepted exp %0h got %0h", e.accepted, out_word.accepted); errors++;
        end
        if (e.out_node !== out_word.out_node) begin
          $error("out_node exp %0h got %0h", e.out_node, out_word.out_node); errors++;
        end
        if (e.acked_base !== out_word.acked_base) begin
          $error("acked_base exp %0h got %0h", e.acked_base, out_word.acked_base);
          errors++;
        end
        if (e.ack_bits !== out_word.ack_bits) begin
          $error("ack_bits exp %0h got %0h", e.ack_bits, out_word.ack_bits); errors++;
        end
        if (e.last_seq !== out_word.last_seq) begin
          $error("last_seq exp %0h got %0h", e.last_seq, out_word.last_seq);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic test_directed;
    send_word(CMD_FLUSH, 8'h00, 8'h00);
    send_word(CMD_RECEIPT, 8'hff, 8'hff);
    send_word(CMD_RECEIPT, 8'hff, 8'h00);
    send_word(CMD_RECEIPT, 8'hff, 8'h02);
    send_word(CMD_RECEIPT, 8'hff, 8'h10);
    send_word(CMD_RECEIPT, 8'hff, 8'h01);
    send_word(CMD_RECEIPT, 8'hff, 8'h01);
    send_word(CMD_RECEIPT, 8'hff, 8'h80);
    send_word(CMD_RECEIPT, 8'hff, 8'h12);
    send_word(CMD_RECEIPT, 8'hff, 8'h91);
    send_word(CMD_FLUSH, 8'hff, 8'hff);
    send_word(CMD_FLUSH, 8'h00, 8'h00);
    send_word(CMD_RECEIPT, 8'hff, 8'h91);
    send_word(CMD_FLUSH, 8'h00, 8'h00);
    for (int k = 0; k < 8; k++) send_word(CMD_RECEIPT, 8'(k), 8'(k * 37));
    send_word(CMD_RECEIPT, 8'h55, 8'haa);
    send_word(CMD_FLUSH, 8'h00, 8'h00);
  endtask

  task automatic test_random(int n);
    logic [7:0] pool [16];
    logic [7:0] nseq [16];
    int p;
    for (int k = 0; k < 16; k++) begin
      pool[k] = $urandom; nseq[k] = $urandom;
    end
    for (int k = 0; k < n; k++) begin
      if (k == n / 3) idle_pct = 0;
      if (k == n / 2) idle_pct = 15;
      if (k == 2 * n / 3) drain();
      if ($urandom_range(99) < 20) begin
        send_word(CMD_FLUSH, 8'($urandom), 8'($urandom));
      end else if ($urandom_range(99) < 8) begin
        send_word(CMD_RECEIPT, 8'($urandom), 8'($urandom));
      end else begin
        p = (k < n / 2) ? $urandom_range(5) : $urandom_range(15);
        case ($urandom_range(9))
          0: nseq[p] = nseq[p] + 8'($urandom_range(17, 127));
          1: nseq[p] = nseq[p] - 8'($urandom_range(0, 128));
          default: nseq[p] = nseq[p] + 8'($urandom_range(1, 17)) - 8'd1;
        endcase
        send_word(CMD_RECEIPT, pool[p], nseq[p]);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_random(1400);
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && ack_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int k = 0; k < NumTrackers; k++) begin
      t_used[k] = 1'b0; t_node[k] = '0; t_started[k] = 1'b0; t_base[k] = '0;
      t_mask[k] = '0; t_dirty[k] = 1'b0; t_dseq[k] = '0; t_svalid[k] = 1'b0;
      t_sbase[k] = '0; t_smask[k] = '0;
    end
  end
endmodule
`default_nettype wire
